FILE: rtl/core/dadt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dadt_pkg
// shared types and constants of the dual absolute encoder delta tracker
// ----------------------------------------------------------------------------
package dadt_pkg;

  localparam int ANGLE_BITS_DEF = 14;
  localparam int TOTAL_BITS_DEF = 32;
  localparam int GAIN_BITS      = 8;
  localparam int DIAG_BITS      = 8;
  localparam int STATUS_BITS    = 2;
  localparam int CFG_DATA_BITS  = 8;
  localparam int CFG_IDX_BITS   = 3;

  localparam int ZERO_OFFSET = 8192;
  localparam int COF_BIT     = 1;

  localparam logic [GAIN_BITS-1:0] GAIN_LOW_RST  = 8'd0;
  localparam logic [GAIN_BITS-1:0] GAIN_HIGH_RST = 8'd255;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK   = 2'd0,
    ST_BUS  = 2'd1,
    ST_COF  = 2'd2,
    ST_GAIN = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FIRST_IS_RIGHT  = 3'd0,
    CFG_INVERT_RIGHT    = 3'd1,
    CFG_INVERT_LEFT     = 3'd2,
    CFG_GAIN_LOW_LIMIT  = 3'd3,
    CFG_GAIN_HIGH_LIMIT = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_BITS-1:0] low;
    logic [GAIN_BITS-1:0] high;
  } gain_lim_t;

  typedef struct packed {
    logic first_is_right;
    logic invert_right;
    logic invert_left;
  } route_t;

  typedef struct packed {
    logic fire;
    logic rezero;
  } step_t;

endpackage
`default_nettype wire

FILE: rtl/core/dadt_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dadt_lane
// one sensor lane: status checks, wrapped angle delta, previous angle
// ----------------------------------------------------------------------------
module dadt_lane import dadt_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire step_t                 step_i,
  input  wire gain_lim_t             lim_i,
  input  wire logic [ANGLE_BITS-1:0] angle_i,
  input  wire logic [GAIN_BITS-1:0]  gain_i,
  input  wire logic [DIAG_BITS-1:0]  diag_i,
  input  wire logic                  bus_ok_i,
  output logic      [ANGLE_BITS-1:0] delta_o,
  output status_e                    status_o
);

  logic [ANGLE_BITS-1:0] prev_q, prev_d;

  // later checks override earlier ones
  always_comb begin
    status_o = ST_OK;
    if (!bus_ok_i) begin
      status_o = ST_BUS;
    end
    if (diag_i[COF_BIT]) begin
      status_o = ST_COF;
    end
    if ((gain_i <= lim_i.low) || (gain_i >= lim_i.high)) begin
      status_o = ST_GAIN;
    end
  end

  assign delta_o = angle_i - prev_q;

  always_comb begin
    prev_d = prev_q;
    if (step_i.fire) begin
      if (!step_i.rezero || (status_o == ST_OK)) begin
        prev_d = angle_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= ANGLE_BITS'(ZERO_OFFSET);
    end else begin
      prev_q <= prev_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/dadt_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dadt_merge
// routes lane deltas to wheels, optionally inverts them, keeps the totals
// ----------------------------------------------------------------------------
module dadt_merge import dadt_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int TOTAL_BITS = TOTAL_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire step_t                 step_i,
  input  wire route_t                route_i,
  input  wire logic [ANGLE_BITS-1:0] delta_a_i,
  input  wire logic [ANGLE_BITS-1:0] delta_b_i,
  output logic      [ANGLE_BITS-1:0] delta_right_o,
  output logic      [ANGLE_BITS-1:0] delta_left_o,
  output logic      [TOTAL_BITS-1:0] total_right_o,
  output logic      [TOTAL_BITS-1:0] total_left_o
);

  logic [ANGLE_BITS-1:0] dr_sel, dl_sel, dr, dl;
  logic [TOTAL_BITS-1:0] sum_right_q, sum_right_d, sum_left_q, sum_left_d;

  always_comb begin
    dr_sel = route_i.first_is_right ? delta_a_i : delta_b_i;
    dl_sel = route_i.first_is_right ? delta_b_i : delta_a_i;
    dr     = route_i.invert_right ? ('0 - dr_sel) : dr_sel;
    dl     = route_i.invert_left  ? ('0 - dl_sel) : dl_sel;
  end

  always_comb begin
    sum_right_d = sum_right_q;
    sum_left_d  = sum_left_q;
    if (step_i.fire) begin
      if (step_i.rezero) begin
        sum_right_d = '0;
        sum_left_d  = '0;
      end else begin
        sum_right_d = sum_right_q + TOTAL_BITS'(signed'(dr));
        sum_left_d  = sum_left_q + TOTAL_BITS'(signed'(dl));
      end
    end
  end

  assign delta_right_o = step_i.rezero ? '0 : dr;
  assign delta_left_o  = step_i.rezero ? '0 : dl;
  assign total_right_o = sum_right_d;
  assign total_left_o  = sum_left_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_right_q <= '0;
      sum_left_q  <= '0;
    end else begin
      sum_right_q <= sum_right_d;
      sum_left_q  <= sum_left_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/dadt_obuf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dadt_obuf
// two-entry result buffer between the datapath and the output channel
// ----------------------------------------------------------------------------
module dadt_obuf import dadt_pkg::*; #(
  parameter int WIDTH = 2 * ANGLE_BITS_DEF + 2 * TOTAL_BITS_DEF + 2 * STATUS_BITS
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic      [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             pop;

  assign full_o      = count_q[1];
  assign out_valid_o = (count_q != 2'd0);
  assign data_o      = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/dual_abs_encoder_delta_tracker.sv
// a result is registered in the two-entry result buffer at its input transfer
// throughput: one item per cycle while the buffer is not full; the two sensor
// lanes and merge run in the transfer cycle, the buffer absorbs output stalls
// reset: previous angles go to the zero offset point, totals to zero, the
// result buffer empties and the registers take their reset values
`default_nettype none
// ----------------------------------------------------------------------------
// dual_abs_encoder_delta_tracker
// two absolute encoder lanes with wrapped deltas and running wheel totals
// ----------------------------------------------------------------------------
module dual_abs_encoder_delta_tracker import dadt_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int TOTAL_BITS = TOTAL_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic        [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic        [CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         command_i,
  input  wire logic        [ANGLE_BITS-1:0] angle_a_i,
  input  wire logic        [GAIN_BITS-1:0]  gain_a_i,
  input  wire logic        [DIAG_BITS-1:0]  diag_a_i,
  input  wire logic                         bus_ok_a_i,
  input  wire logic        [ANGLE_BITS-1:0] angle_b_i,
  input  wire logic        [GAIN_BITS-1:0]  gain_b_i,
  input  wire logic        [DIAG_BITS-1:0]  diag_b_i,
  input  wire logic                         bus_ok_b_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic signed      [ANGLE_BITS-1:0] delta_right_o,
  output logic signed      [ANGLE_BITS-1:0] delta_left_o,
  output logic signed      [TOTAL_BITS-1:0] total_right_o,
  output logic signed      [TOTAL_BITS-1:0] total_left_o,
  output logic             [STATUS_BITS-1:0] status_a_o,
  output logic             [STATUS_BITS-1:0] status_b_o
);

  localparam int RES_W = 2 * ANGLE_BITS + 2 * TOTAL_BITS + 2 * STATUS_BITS;

  route_t    route_q;
  gain_lim_t lim_q;
  step_t     step;
  logic      full;

  logic [ANGLE_BITS-1:0] delta_a, delta_b, dr, dl;
  logic [TOTAL_BITS-1:0] tr, tl;
  status_e               st_a, st_b;
  logic [RES_W-1:0]      res, res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      route_q.first_is_right <= 1'b1;
      route_q.invert_right   <= 1'b0;
      route_q.invert_left    <= 1'b0;
      lim_q.low              <= GAIN_LOW_RST;
      lim_q.high             <= GAIN_HIGH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FIRST_IS_RIGHT:  route_q.first_is_right <= cfg_wdata_i[0];
        CFG_INVERT_RIGHT:    route_q.invert_right   <= cfg_wdata_i[0];
        CFG_INVERT_LEFT:     route_q.invert_left    <= cfg_wdata_i[0];
        CFG_GAIN_LOW_LIMIT:  lim_q.low              <= cfg_wdata_i[GAIN_BITS-1:0];
        CFG_GAIN_HIGH_LIMIT: lim_q.high             <= cfg_wdata_i[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o  = !full;
  assign step.fire   = in_valid_i && in_ready_o;
  assign step.rezero = command_i;

  dadt_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane_a (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .lim_i    (lim_q),
    .angle_i  (angle_a_i),
    .gain_i   (gain_a_i),
    .diag_i   (diag_a_i),
    .bus_ok_i (bus_ok_a_i),
    .delta_o  (delta_a),
    .status_o (st_a)
  );

  dadt_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .lim_i    (lim_q),
    .angle_i  (angle_b_i),
    .gain_i   (gain_b_i),
    .diag_i   (diag_b_i),
    .bus_ok_i (bus_ok_b_i),
    .delta_o  (delta_b),
    .status_o (st_b)
  );

  dadt_merge #(.ANGLE_BITS(ANGLE_BITS), .TOTAL_BITS(TOTAL_BITS)) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .route_i       (route_q),
    .delta_a_i     (delta_a),
    .delta_b_i     (delta_b),
    .delta_right_o (dr),
    .delta_left_o  (dl),
    .total_right_o (tr),
    .total_left_o  (tl)
  );

  assign res = {dr, dl, tr, tl, st_a, st_b};

  dadt_obuf #(.WIDTH(RES_W)) u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step.fire),
    .data_i      (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (res_out)
  );

  assign {delta_right_o, delta_left_o, total_right_o, total_left_o, status_a_o, status_b_o}
    = res_out;

endmodule
`default_nettype wire

FILE: rtl/core/dadt_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dadt_checker
// port level checks of the delta tracker, bound to its top level
// ----------------------------------------------------------------------------
module dadt_checker import dadt_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int TOTAL_BITS = TOTAL_BITS_DEF
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_ready_o,
  input wire logic                  command_i,
  input wire logic                  out_valid_o,
  input wire logic                  out_ready_i,
  input wire logic [ANGLE_BITS-1:0] delta_right_o,
  input wire logic [ANGLE_BITS-1:0] delta_left_o,
  input wire logic [TOTAL_BITS-1:0] total_right_o,
  input wire logic [TOTAL_BITS-1:0] total_left_o
);

  // a waiting result is not dropped
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // input side only stalls while results are queued
  a_ready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty buffer");

  // a transfer into an empty buffer shows a result next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> out_valid_o)
    else $error("result missing after transfer");

  // a rezero into an empty buffer reports zero deltas and cleared totals
  a_rezero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o && command_i |=>
      (delta_right_o == '0) && (delta_left_o == '0) &&
      (total_right_o == '0) && (total_left_o == '0))
    else $error("rezero result not cleared");

endmodule

bind dual_abs_encoder_delta_tracker dadt_checker #(
  .ANGLE_BITS(ANGLE_BITS),
  .TOTAL_BITS(TOTAL_BITS)
) u_dadt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .command_i     (command_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .delta_right_o (delta_right_o),
  .delta_left_o  (delta_left_o),
  .total_right_o (total_right_o),
  .total_left_o  (total_left_o)
);
`default_nettype wire
